/* design/cls_pkg.sv */
// Package for the charlieplexed LED scanner: shared types, constants,
// register indexes and the pin lookup tables. No dependencies.
package cls_pkg;

  typedef logic [4:0] pins_t;
  typedef logic [5:0] pos_t;
  typedef logic [7:0] ticks_t;
  typedef logic [4:0] tidx_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCAN_MODE  = 1'b0,
    CFG_STEP_TICKS = 1'b1
  } cfg_idx_t;

  localparam pos_t   SCAN_LAST   = 6'd37;
  localparam pos_t   FWD_STEPS   = 6'd20;
  localparam pos_t   MIRROR_BASE = 6'd39;
  localparam ticks_t TICKS_RESET = 8'd30;
  localparam pins_t  OFF_LEVEL   = 5'b11111;
  localparam pins_t  OFF_ENABLE  = 5'b00000;

  // Scan position to table index: forward sweep, then back down to 2
  function automatic tidx_t table_index(input pos_t pos);
    pos_t mirrored;
    mirrored = MIRROR_BASE - pos;
    if (pos < FWD_STEPS) begin
      return pos[4:0];
    end else begin
      return mirrored[4:0];
    end
  endfunction

  // Pin-enable mask, one pin pair per entry
  function automatic pins_t enable_at(input logic [3:0] pair);
    case (pair)
      4'd0:    return 5'b00011;
      4'd1:    return 5'b00101;
      4'd2:    return 5'b01001;
      4'd3:    return 5'b10001;
      4'd4:    return 5'b00110;
      4'd5:    return 5'b01010;
      4'd6:    return 5'b10010;
      4'd7:    return 5'b01100;
      4'd8:    return 5'b10100;
      4'd9:    return 5'b11000;
      default: return 5'b00000;
    endcase
  endfunction

  // Pin levels, high side of the lit LED
  function automatic pins_t level_at(input tidx_t idx);
    case (idx)
      5'd0:    return 5'b00001;
      5'd1:    return 5'b00010;
      5'd2:    return 5'b00001;
      5'd3:    return 5'b00100;
      5'd4:    return 5'b00001;
      5'd5:    return 5'b01000;
      5'd6:    return 5'b00001;
      5'd7:    return 5'b10000;
      5'd8:    return 5'b00010;
      5'd9:    return 5'b00100;
      5'd10:   return 5'b00010;
      5'd11:   return 5'b01000;
      5'd12:   return 5'b00010;
      5'd13:   return 5'b10000;
      5'd14:   return 5'b00100;
      5'd15:   return 5'b01000;
      5'd16:   return 5'b00100;
      5'd17:   return 5'b10000;
      5'd18:   return 5'b01000;
      5'd19:   return 5'b10000;
      default: return 5'b00000;
    endcase
  endfunction

endpackage

/* design/charlieplex_led_scanner_top.sv */
// Charlieplexed LED scanner top level: scan state, config registers and
// the registered result stage. Depends on cls_pkg.
//
// Each input beat is one timer tick and yields one result beat with the
// pin-enable mask, pin levels and the scan step in effect for that tick.
// The block takes one tick per clock cycle: the step/hold counters and the
// table lookups sit between the input handshake and a single result
// register, and a new tick is accepted whenever that register is empty or
// is being drained in the same cycle. Configuration writes (scan mode,
// hold ticks) apply to the next tick; a changed hold count is picked up
// at the next step reload.
module charlieplex_led_scanner_top (
  input  logic                 clk,
  input  logic                 rst,
  // tick channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output cls_pkg::pins_t       pin_enable,
  output cls_pkg::pins_t       pin_level,
  output cls_pkg::pos_t        step_position,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cls_pkg::cfg_idx_t    cfg_index,
  input  cls_pkg::ticks_t      cfg_data
);

  logic            scan_mode;
  cls_pkg::ticks_t step_ticks;
  cls_pkg::pos_t   position, position_next;
  cls_pkg::ticks_t ticks_left, ticks_left_next;
  logic            in_fire;
  cls_pkg::ticks_t hold;
  cls_pkg::pos_t   cur_pos;
  cls_pkg::tidx_t  tidx;
  cls_pkg::pins_t  enable_next, level_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode  <= 1'b0;
      step_ticks <= cls_pkg::TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cls_pkg::CFG_SCAN_MODE:  scan_mode  <= cfg_data[0];
        cls_pkg::CFG_STEP_TICKS: step_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick evaluation
  always_comb begin
    hold = (step_ticks == '0) ? 8'd1 : step_ticks;
    if (restart || position > cls_pkg::SCAN_LAST) begin
      cur_pos = '0;
    end else begin
      cur_pos = position;
    end
    tidx            = cls_pkg::table_index(cur_pos);
    position_next   = cur_pos;
    ticks_left_next = restart ? hold : ticks_left;
    if (scan_mode) begin
      enable_next = cls_pkg::OFF_ENABLE;
      level_next  = cls_pkg::OFF_LEVEL;
    end else begin
      enable_next = cls_pkg::enable_at(tidx[4:1]);
      level_next  = cls_pkg::level_at(tidx);
      if (!restart) begin
        if (ticks_left <= 8'd1) begin
          position_next   = (cur_pos == cls_pkg::SCAN_LAST) ? '0 : cur_pos + 6'd1;
          ticks_left_next = hold;
        end else begin
          ticks_left_next = ticks_left - 8'd1;
        end
      end
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      ticks_left <= cls_pkg::TICKS_RESET;
    end else if (in_fire) begin
      position   <= position_next;
      ticks_left <= ticks_left_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pin_enable    <= enable_next;
      pin_level     <= level_next;
      step_position <= cur_pos;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= cls_pkg::SCAN_LAST)
    else $error("scan position out of range");

  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    ticks_left != '0)
    else $error("hold counter reached zero");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && restart |=> position == '0 && step_position == '0 && out_valid)
    else $error("restart did not return to step zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && !restart && !scan_mode && ticks_left > 8'd1
    |=> $stable(position))
    else $error("position moved while step still held");

  a_off_frozen: assert property (@(posedge clk) disable iff (rst)
    in_fire && !restart && scan_mode |=> $stable(position) && $stable(ticks_left))
    else $error("scan advanced in off mode");
`endif

endmodule
